// ----- hdl/rbst_pkg.sv -----
// Shared types and constants for the ray versus box slab test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rbst_pkg;

  // Q16.16 coordinates, Q1.14 directions
  localparam int CW       = 32;
  localparam int DW       = 16;
  localparam int DIR_FRAC = 14;
  // magnitude of (bound - origin) fits CW bits; numerator adds the 14 fraction bits
  localparam int NW       = CW + DIR_FRAC;
  // signed distance width with room for the unbounded markers
  localparam int TW       = NW + 2;

  localparam logic signed [CW-1:0] Z_LO = CW'(0);
  localparam logic signed [CW-1:0] Z_HI = CW'(200 * 65536);

  // configuration register indexes
  localparam logic [1:0] REG_BOX_MIN_X = 2'd0;
  localparam logic [1:0] REG_BOX_MIN_Y = 2'd1;
  localparam logic [1:0] REG_BOX_MAX_X = 2'd2;
  localparam logic [1:0] REG_BOX_MAX_Y = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] entry_distance;
  } result_t;

  // per-slab classification from the front end
  typedef struct packed {
    logic neg_lo;      // quotient for first bound is negative
    logic neg_hi;      // quotient for second bound is negative
    logic dzero;       // direction component is zero
    logic contained;   // origin lies between the bounds
  } slab_flags_t;

  typedef struct packed {
    logic [NW-1:0] num_lo;
    logic [NW-1:0] num_hi;
    logic [DW-1:0] den;
    slab_flags_t   flags;
  } slab_job_t;

  typedef slab_job_t [2:0] ray_job_t;

endpackage

// ----- hdl/rbst_front.sv -----
// Front end: box registers, ray intake, numerator and divisor setup per slab.
// Depends on rbst_pkg.
`timescale 1ns / 1ps
module rbst_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [1:0]               cfg_index,
  input  logic [rbst_pkg::CW-1:0]  cfg_data,
  input  logic                     ray_valid,
  output logic                     ray_stall,
  input  rbst_pkg::ray_t           ray,
  output logic                     job_valid,
  input  logic                     job_full,
  output rbst_pkg::ray_job_t       job
);
  import rbst_pkg::*;

  logic signed [CW-1:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  logic signed [CW-1:0] org [3];
  logic signed [DW-1:0] dir [3];
  ray_job_t             job_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min_x <= cfg_data;
        REG_BOX_MIN_Y: box_min_y <= cfg_data;
        REG_BOX_MAX_X: box_max_x <= cfg_data;
        REG_BOX_MAX_Y: box_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lo[0]  = box_min_x;
  assign lo[1]  = box_min_y;
  assign lo[2]  = Z_LO;
  assign hi[0]  = box_max_x;
  assign hi[1]  = box_max_y;
  assign hi[2]  = Z_HI;
  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.dir_x;
  assign dir[1] = ray.dir_y;
  assign dir[2] = ray.dir_z;

  // per slab: differences, magnitudes, signs, containment
  always_comb begin
    logic signed [CW:0] dl, dh;
    logic        [CW:0] ml, mh;
    logic        [DW-1:0] md;
    for (int a = 0; a < 3; a++) begin
      dl = {lo[a][CW-1], lo[a]} - {org[a][CW-1], org[a]};
      dh = {hi[a][CW-1], hi[a]} - {org[a][CW-1], org[a]};
      ml = dl[CW] ? -dl : dl;
      mh = dh[CW] ? -dh : dh;
      md = dir[a][DW-1] ? -dir[a] : dir[a];
      job_next[a].num_lo          = {ml[CW-1:0], {DIR_FRAC{1'b0}}};
      job_next[a].num_hi          = {mh[CW-1:0], {DIR_FRAC{1'b0}}};
      job_next[a].den             = md;
      job_next[a].flags.neg_lo    = dl[CW] ^ dir[a][DW-1];
      job_next[a].flags.neg_hi    = dh[CW] ^ dir[a][DW-1];
      job_next[a].flags.dzero     = (dir[a] == '0);
      job_next[a].flags.contained = ((org[a] >= lo[a]) && (org[a] <= hi[a])) ||
                                    ((org[a] >= hi[a]) && (org[a] <= lo[a]));
    end
  end

  // intake register
  assign ray_stall = job_valid && job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!ray_stall) begin
      job_valid <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ray_stall && ray_valid) begin
      job <= job_next;
    end
  end

endmodule

// ----- hdl/rbst_queue.sv -----
// Short job queue between front end and back end.
// Depends on rbst_pkg.
`timescale 1ns / 1ps
module rbst_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rbst_pkg::ray_job_t push_job,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output rbst_pkg::ray_job_t pop_job
);
  import rbst_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  ray_job_t      mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

// ----- hdl/rbst_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rbst_pkg.
`timescale 1ns / 1ps
module rbst_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rbst_pkg::NW-1:0] num,
  input  logic [rbst_pkg::DW-1:0] den,
  output logic [rbst_pkg::NW-1:0] quo
);
  import rbst_pkg::*;

  logic [DW-1:0] r_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [NW-1:0] q_q [NW];
  logic [DW-1:0] d_q [NW];
  logic [DW-1:0] r_next [NW];
  logic [NW-1:0] n_next [NW];
  logic [NW-1:0] q_next [NW];
  logic [DW-1:0] d_next [NW];

  // each stage brings down one numerator bit and tries a subtract
  always_comb begin
    logic [DW-1:0] r_in, d_in;
    logic [NW-1:0] n_in, q_in;
    logic [DW:0]   t;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        r_in = '0;
        n_in = num;
        q_in = '0;
        d_in = den;
      end else begin
        r_in = r_q[s-1];
        n_in = n_q[s-1];
        q_in = q_q[s-1];
        d_in = d_q[s-1];
      end
      t = {r_in, n_in[NW-1]};
      if (t >= {1'b0, d_in}) begin
        t         = t - {1'b0, d_in};
        q_next[s] = {q_in[NW-2:0], 1'b1};
      end else begin
        q_next[s] = {q_in[NW-2:0], 1'b0};
      end
      r_next[s] = t[DW-1:0];
      n_next[s] = {n_in[NW-2:0], 1'b0};
      d_next[s] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        r_q[s] <= r_next[s];
        n_q[s] <= n_next[s];
        q_q[s] <= q_next[s];
        d_q[s] <= d_next[s];
      end
    end
  end

  assign quo = q_q[NW-1];

endmodule

// ----- hdl/rbst_back.sv -----
// Back end: six slab divisions, interval narrowing, hit decision, output register.
// Depends on rbst_pkg and rbst_div.
`timescale 1ns / 1ps
module rbst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  rbst_pkg::ray_job_t job,
  output logic               job_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output rbst_pkg::result_t  result
);
  import rbst_pkg::*;

  localparam logic signed [TW-1:0] NEG_INF = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] POS_INF = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_HI  = TW'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO  = -SAT_HI - TW'(1);

  logic          adv;
  logic [NW-1:0] q_lo [3];
  logic [NW-1:0] q_hi [3];

  // sideband line aligned with the divider stages
  logic          side_valid [NW];
  slab_flags_t   side_flags [NW][3];

  logic                 a_valid, a_ok;
  logic signed [TW-1:0] a_near [3];
  logic signed [TW-1:0] a_far  [3];
  logic                 b_valid, b_ok;
  logic signed [TW-1:0] b_tn, b_tf;

  // whole pipeline moves unless the result is held
  assign adv     = !(result_valid && result_stall);
  assign job_pop = adv && job_valid;

  for (genvar a = 0; a < 3; a++) begin : g_slab
    rbst_div u_div_lo (.clk(clk), .en(adv), .num(job[a].num_lo), .den(job[a].den),
                       .quo(q_lo[a]));
    rbst_div u_div_hi (.clk(clk), .en(adv), .num(job[a].num_hi), .den(job[a].den),
                       .quo(q_hi[a]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NW; s++) side_valid[s] <= 1'b0;
    end else if (adv) begin
      side_valid[0] <= job_valid;
      for (int s = 1; s < NW; s++) side_valid[s] <= side_valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) side_flags[0][a] <= job[a].flags;
      for (int s = 1; s < NW; s++) side_flags[s] <= side_flags[s-1];
    end
  end

  // signed distances, ordered per slab
  logic signed [TW-1:0] near_next [3];
  logic signed [TW-1:0] far_next  [3];
  logic                 ok_next;
  always_comb begin
    logic signed [TW-1:0] tl, th;
    slab_flags_t f;
    ok_next = 1'b1;
    for (int a = 0; a < 3; a++) begin
      f  = side_flags[NW-1][a];
      tl = f.neg_lo ? -$signed({2'b00, q_lo[a]}) : $signed({2'b00, q_lo[a]});
      th = f.neg_hi ? -$signed({2'b00, q_hi[a]}) : $signed({2'b00, q_hi[a]});
      if (f.dzero) begin
        near_next[a] = NEG_INF;
        far_next[a]  = POS_INF;
        ok_next      = ok_next && f.contained;
      end else if (tl > th) begin
        near_next[a] = th;
        far_next[a]  = tl;
      end else begin
        near_next[a] = tl;
        far_next[a]  = th;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= side_valid[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ok <= ok_next;
      for (int a = 0; a < 3; a++) begin
        a_near[a] <= near_next[a];
        a_far[a]  <= far_next[a];
      end
    end
  end

  // largest entry, smallest exit
  logic signed [TW-1:0] tn_next, tf_next;
  always_comb begin
    tn_next = a_near[0];
    tf_next = a_far[0];
    for (int a = 1; a < 3; a++) begin
      if (a_near[a] > tn_next) tn_next = a_near[a];
      if (a_far[a] < tf_next)  tf_next = a_far[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ok <= a_ok;
      b_tn <= tn_next;
      b_tf <= tf_next;
    end
  end

  // hit decision and saturation into the output register
  result_t res_next;
  always_comb begin
    res_next.hit = b_ok && !b_tf[TW-1] && (b_tn <= b_tf);
    priority if (!res_next.hit) res_next.entry_distance = '0;
    else if (b_tn < SAT_LO)     res_next.entry_distance = SAT_LO[CW-1:0];
    else if (b_tn > SAT_HI)     res_next.entry_distance = SAT_HI[CW-1:0];
    else                        res_next.entry_distance = b_tn[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("held result changed");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |-> (result.entry_distance == '0))
    else $error("miss with nonzero distance");
  a_pop_adv: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> side_valid[0])
    else $error("popped job lost in pipeline");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(b_valid) && $stable(a_valid)))
    else $error("pipeline moved while stalled");

endmodule

// ----- hdl/ray_box_slab_test_top.sv -----
// Path from accept to result: intake register, queue, 46 divider stages, ordering, narrowing, output register.
// Throughput: one ray per cycle while no result is held; the 46-stage pipelined dividers, six in parallel, set it.
// Back end stalls as a whole while a result is held; the 4-entry queue absorbs in-flight rays.
// Reset (synchronous, rst high) clears box registers to 0 and empties all stages.
// Depends on rbst_pkg, rbst_front, rbst_queue, rbst_div, rbst_back.
`timescale 1ns / 1ps
module ray_box_slab_test_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [1:0]              cfg_index,
  input  logic [rbst_pkg::CW-1:0] cfg_data,
  input  logic                    ray_valid,
  output logic                    ray_stall,
  input  rbst_pkg::ray_t          ray,
  output logic                    result_valid,
  input  logic                    result_stall,
  output rbst_pkg::result_t       result
);
  import rbst_pkg::*;

  logic     f_valid, q_full, q_pop, q_valid;
  ray_job_t f_job, q_job;

  rbst_front u_front (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .job_valid(f_valid), .job_full(q_full), .job(f_job)
  );

  rbst_queue u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid && !q_full), .push_job(f_job), .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_job(q_job)
  );

  rbst_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(q_valid), .job(q_job), .job_pop(q_pop),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

endmodule

// ----- sim/tb_ray_box_slab_test_top.sv -----
// Testbench for ray_box_slab_test_top: queue-fed driver, clocked monitor, bit-exact predictor.
// Depends on rbst_pkg and the ray_box_slab_test_top RTL.
`timescale 1ns / 1ps
module tb_ray_box_slab_test_top;
  import rbst_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_index = REG_BOX_MIN_X;
  logic [CW-1:0] cfg_data = '0;
  logic ray_valid = 1'b0;
  logic ray_stall;
  ray_t ray = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  ray_box_slab_test_top uut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // box bounds as the predictor sees them
  logic signed [CW-1:0] bx_lo, by_lo, bx_hi, by_hi;

  ray_t    pending_rays[$];
  result_t expected_results[$];
  int      error_count = 0;
  int      rays_sent = 0;
  int      results_seen = 0;
  int      hits_seen = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 1'b0;

  // truncating division of (b - o) << 14 by d, exact in 64 bits
  function automatic longint slab_distance(longint b, longint o, longint d);
    longint num, n, dd, q;
    num = b - o;
    n  = (num < 0) ? -num : num;
    dd = (d < 0) ? -d : d;
    q  = (n <<< DIR_FRAC) / dd;
    return (((num < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic bit narrow_slab(longint lo, longint hi, longint o, longint d,
                                     inout longint tn, inout longint tf);
    longint a, b, t;
    if (d == 0) begin
      return (o >= ((lo < hi) ? lo : hi)) && (o <= ((lo < hi) ? hi : lo));
    end
    a = slab_distance(lo, o, d);
    b = slab_distance(hi, o, d);
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (a > tn) tn = a;
    if (b < tf) tf = b;
    return 1'b1;
  endfunction

  function automatic result_t predict_hit(ray_t r);
    longint tn, tf, lim;
    bit ok;
    result_t res;
    tn = 64'sh8000_0000_0000_0000;
    tf = 64'sh7fff_ffff_ffff_ffff;
    lim = 64'sd1 <<< (CW - 1);
    ok = narrow_slab(longint'(bx_lo), longint'(bx_hi), longint'(r.origin_x),
                     longint'(r.dir_x), tn, tf);
    ok = narrow_slab(longint'(by_lo), longint'(by_hi), longint'(r.origin_y),
                     longint'(r.dir_y), tn, tf) && ok;
    ok = narrow_slab(longint'(Z_LO), longint'(Z_HI), longint'(r.origin_z),
                     longint'(r.dir_z), tn, tf) && ok;
    res = '0;
    if (ok && tf >= 0 && tn <= tf) begin
      if (tn < -lim) tn = -lim;
      if (tn > lim - 1) tn = lim - 1;
      res.hit = 1'b1;
      res.entry_distance = tn[CW-1:0];
    end
    return res;
  endfunction

  // random coordinate: mostly near the box, sometimes anywhere
  function automatic logic [CW-1:0] pick_coord(logic signed [CW-1:0] lo,
                                              logic signed [CW-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return lo;
      3: return hi;
      default: return lo + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DW'($urandom_range(0, 3));
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r.origin_x = pick_coord(bx_lo, bx_hi);
    r.origin_y = pick_coord(by_lo, by_hi);
    r.origin_z = pick_coord(Z_LO, Z_HI);
    r.dir_x = pick_dir();
    r.dir_y = pick_dir();
    r.dir_z = pick_dir();
    return r;
  endfunction

  // ray driver: random gap per transaction
  int send_gap = 0;
  always @(posedge clk) begin
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (rst) begin
      ray_valid <= 1'b0;
    end else if (ray_valid && !ray_stall) begin
      rays_sent <= rays_sent + 1;
      expected_results.push_back(predict_hit(ray));
      if (pending_rays.size() > 0 && gap == 0) begin
        ray <= pending_rays.pop_front();
      end else begin
        ray_valid <= 1'b0;
        send_gap  <= (gap > 0) ? gap - 1 : 0;
      end
    end else if (!ray_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_rays.size() > 0) begin
        ray <= pending_rays.pop_front();
        ray_valid <= 1'b1;
      end
    end
  end

  // result monitor with random stall per transaction
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0b entry=%h", $time, result.hit,
                   result.entry_distance);
          error_count++;
        end else begin
          result_t exp_r;
          exp_r = expected_results.pop_front();
          if (result.hit !== exp_r.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, exp_r.hit, result.hit);
            error_count++;
          end
          if (result.entry_distance !== exp_r.entry_distance) begin
            $display("%0t: entry_distance mismatch expected %h actual %h", $time,
                     exp_r.entry_distance, result.entry_distance);
            error_count++;
          end
          if (exp_r.hit) hits_seen <= hits_seen + 1;
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((ray_valid && !ray_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else if (!rst && (pending_rays.size() > 0 || ray_valid || expected_results.size() > 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_box(logic [1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BOX_MIN_X: bx_lo = val;
      REG_BOX_MIN_Y: by_lo = val;
      REG_BOX_MAX_X: bx_hi = val;
      default:       by_hi = val;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_box(logic [CW-1:0] x0, logic [CW-1:0] y0,
                         logic [CW-1:0] x1, logic [CW-1:0] y1);
    write_box(REG_BOX_MIN_X, x0);
    write_box(REG_BOX_MIN_Y, y0);
    write_box(REG_BOX_MAX_X, x1);
    write_box(REG_BOX_MAX_Y, y1);
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || ray_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic ray_t make_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                                    logic [DW-1:0] dx, logic [DW-1:0] dy, logic [DW-1:0] dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  initial begin
    bx_lo = '0; by_lo = '0; bx_hi = '0; by_hi = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: box 10..20 in x and y
    set_box(32'h000a_0000, 32'h000a_0000, 32'h0014_0000, 32'h0014_0000);
    // straight down the middle, all directions positive
    pending_rays.push_back(make_ray(0, 0, 32'hfff6_0000, 16'h4000, 16'h4000, 16'h4000));
    // all directions zero, origin inside: unbounded hit
    pending_rays.push_back(make_ray(32'h000f_0000, 32'h000f_0000, 32'h0064_0000,
                                    16'h0000, 16'h0000, 16'h0000));
    // zero directions, origin outside in x
    pending_rays.push_back(make_ray(32'h0001_0000, 32'h000f_0000, 32'h0064_0000,
                                    16'h0000, 16'h0000, 16'h0000));
    // zero direction with origin on a bound
    pending_rays.push_back(make_ray(32'h000a_0000, 32'h0014_0000, 0,
                                    16'h0000, 16'h0000, 16'h4000));
    // box behind the ray
    pending_rays.push_back(make_ray(32'h0064_0000, 32'h000f_0000, 32'h0064_0000,
                                    16'h4000, 16'h0000, 16'h0000));
    // tiny direction: saturates the distance
    pending_rays.push_back(make_ray(32'h8000_0000, 32'h000f_0000, 32'h0064_0000,
                                    16'h0001, 16'h0000, 16'h0000));
    // extremes of origin and direction
    pending_rays.push_back(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                    16'h8000, 16'h7fff, 16'h8000));
    pending_rays.push_back(make_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                    16'hffff, 16'hffff, 16'hffff));
    pending_rays.push_back(make_ray(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff));
    drain();

    // swapped bounds, extremes of the register range
    set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    pending_rays.push_back(make_ray(0, 0, 32'h0001_0000, 16'h0000, 16'h0001, 16'h8000));
    pending_rays.push_back(make_ray(32'h8000_0000, 32'h7fff_ffff, 0,
                                    16'h0001, 16'hffff, 16'h0000));
    pending_rays.push_back(make_ray(32'h1234_5678, 32'hedcb_a987, 32'h0032_0000,
                                    16'h2000, 16'he000, 16'h0000));
    drain();

    // random phases over several boxes, one phase without gaps
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_box(32'hfff0_0000, 32'hfff0_0000, 32'h0010_0000, 32'h0010_0000);
        1: set_box(32'h0020_0000, 32'h0030_0000, 32'h0010_0000, 32'hffe0_0000);
        2: set_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        3: set_box(0, 0, 0, 0);
        default: set_box($urandom, $urandom, $urandom, $urandom);
      endcase
      no_gaps = (phase == 4);
      for (int i = 0; i < 250; i++) pending_rays.push_back(random_ray());
      drain();
    end
    no_gaps = 1'b0;

    $display("Sent %0d rays over several box settings; %0d results checked, %0d hits.",
             rays_sent, results_seen, hits_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/rbst_pkg.sv
hdl/rbst_front.sv
hdl/rbst_queue.sv
hdl/rbst_div.sv
hdl/rbst_back.sv
hdl/ray_box_slab_test_top.sv
sim/tb_ray_box_slab_test_top.sv
